/* hdl/lszsl_pkg.sv */
// shared types, constants and tables for the lidar safety zone speed limiter
// no dependencies; imported by every module of the block
package lszsl_pkg;

  // trig resolution
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  // cordic datapath
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int CW           = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [31:0] PHASE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  // trig and product widths
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = 17 + TRIG_W;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // result queue
  localparam int OUT_DEPTH = 2;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_POINT = 2'd1,
    REQ_CMD   = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH  = 3'd0,
    CFG_HARD_MARGIN = 3'd1,
    CFG_SOFT_MARGIN = 3'd2,
    CFG_SOFT_SPEED  = 3'd3,
    CFG_MIN_RANGE   = 3'd4,
    CFG_ANGLE_START = 3'd5,
    CFG_ANGLE_STEP  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] half_width;
    logic [11:0] hard_margin;
    logic [11:0] soft_margin;
    logic [14:0] soft_speed;
    logic [11:0] min_range;
    logic [15:0] angle_start;
    logic [15:0] angle_step;
  } cfg_t;

  // one work item on its way through the back end
  typedef struct packed {
    req_e               kind;
    logic        [15:0] angle;
    logic        [15:0] range;
    logic signed [15:0] lin_x;
    logic signed [15:0] lin_y;
    logic signed [15:0] ang_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] lin_x;
    logic signed [15:0] lin_y;
    logic signed [15:0] ang_z;
    logic               hard_zone;
    logic               soft_zone;
  } res_t;

  // back end status towards the top level
  typedef struct packed {
    logic adv;
    logic hard_zone;
    logic soft_zone;
  } ctl_t;

  // arctangent of 2^-i in units of 2pi/2^32
  function automatic logic [31:0] atan_turn(input logic [STEP_IDX_W-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* hdl/lszsl_front.sv */
// front end: accepts requests, tracks the scan point angle, drops invalid points
// depends on lszsl_pkg
module lszsl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [1:0]          req_type_i,
  input  logic [15:0]         range_mm_i,
  input  logic signed [15:0]  cmd_linear_x_i,
  input  logic signed [15:0]  cmd_linear_y_i,
  input  logic signed [15:0]  cmd_angular_z_i,
  input  lszsl_pkg::cfg_t     cfg_i,
  output logic                wr_o,
  output lszsl_pkg::item_t    item_o
);
  import lszsl_pkg::*;

  logic        accept;
  logic [15:0] angle_q, angle_d;

  assign accept = push_i && !full_i;

  always_comb begin
    angle_d = angle_q;
    wr_o    = 1'b0;
    unique case (req_e'(req_type_i))
      REQ_SCAN: begin
        angle_d = cfg_i.angle_start;
        wr_o    = accept;
      end
      REQ_POINT: begin
        // angle advances for skipped points too
        angle_d = angle_q + cfg_i.angle_step;
        wr_o    = accept && (range_mm_i > {4'd0, cfg_i.min_range});
      end
      REQ_CMD: begin
        wr_o = accept;
      end
      default: begin
        wr_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (accept) begin
      angle_q <= angle_d;
    end
  end

  assign item_o.kind  = req_e'(req_type_i);
  assign item_o.angle = angle_q;
  assign item_o.range = range_mm_i;
  assign item_o.lin_x = cmd_linear_x_i;
  assign item_o.lin_y = cmd_linear_y_i;
  assign item_o.ang_z = cmd_angular_z_i;

endmodule

/* hdl/lszsl_fifo.sv */
// short item queue between the front end and the back end
// depends on lszsl_pkg
module lszsl_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  lszsl_pkg::item_t item_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             empty_o,
  output lszsl_pkg::item_t item_o
);
  import lszsl_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hdl/lszsl_cordic.sv */
// pipelined rotation cordic, one step per stage, item carried alongside
// depends on lszsl_pkg
module lszsl_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  lszsl_pkg::item_t               item_i,
  output logic                           valid_o,
  output lszsl_pkg::item_t               item_o,
  output logic signed [lszsl_pkg::CW-1:0] cos_o,
  output logic signed [lszsl_pkg::CW-1:0] sin_o
);
  import lszsl_pkg::*;

  logic [CORDIC_STEPS-1:0] vld_q;
  item_t                   itm_q [CORDIC_STEPS];
  logic signed [CW-1:0]    x_q   [CORDIC_STEPS];
  logic signed [CW-1:0]    y_q   [CORDIC_STEPS];
  logic signed [CW-1:0]    z_q   [CORDIC_STEPS];
  logic [31:0]             phase;

  // quadrant bits stay with the item, the rest drives the rotation
  assign phase = {item_i.angle, 16'h0000} & PHASE_KEEP;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic signed [CW-1:0] xi, yi, zi, dx, dy, at;
    logic                 vi;
    item_t                ii;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = $signed(CW'(phase[29:0]));
      assign vi = valid_i;
      assign ii = item_i;
    end else begin : g_rest
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign vi = vld_q[i-1];
      assign ii = itm_q[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = $signed(CW'(atan_turn(STEP_IDX_W'(i))));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        itm_q[i] <= ii;
        if (!zi[CW-1]) begin
          x_q[i] <= xi - dx;
          y_q[i] <= yi + dy;
          z_q[i] <= zi - at;
        end else begin
          x_q[i] <= xi + dx;
          y_q[i] <= yi - dy;
          z_q[i] <= zi + at;
        end
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STEPS-1];
  assign item_o  = itm_q[CORDIC_STEPS-1];
  assign cos_o   = x_q[CORDIC_STEPS-1];
  assign sin_o   = y_q[CORDIC_STEPS-1];

endmodule

/* hdl/lszsl_back.sv */
// back end: trig rounding, point projection, zone flags, speed limit, result queue
// depends on lszsl_pkg
module lszsl_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  lszsl_pkg::item_t                item_i,
  input  logic signed [lszsl_pkg::CW-1:0] cos_i,
  input  logic signed [lszsl_pkg::CW-1:0] sin_i,
  input  lszsl_pkg::cfg_t                 cfg_i,
  input  logic                            pop_i,
  output logic                            empty_o,
  output lszsl_pkg::res_t                 res_o,
  output lszsl_pkg::ctl_t                 ctl_o
);
  import lszsl_pkg::*;

  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic signed [CW-1:0] RND     = CW'(1) <<< (SH - 1);
  localparam logic signed [CW-1:0] ONE_CW  = CW'(1) <<< TRIG_FRAC_BITS;
  localparam logic signed [TRIG_W-1:0] ONE = TRIG_W'(1) <<< TRIG_FRAC_BITS;

  function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [TRIG_W-1:0] t;
    r = (v + RND) >>> SH;
    if (r > ONE_CW) begin
      t = ONE;
    end else if (r < -ONE_CW) begin
      t = -ONE;
    end else begin
      t = TRIG_W'(r);
    end
    return t;
  endfunction

  logic                     adv;
  logic                     t_vld_q, p_vld_q;
  item_t                    t_itm_q, p_itm_q;
  logic signed [TRIG_W-1:0] c_r, s_r, t_cos_q, t_sin_q, t_cos_d, t_sin_d;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic signed [PROD_W-1:0] hb, sb, hlim, slim;
  logic                     in_hard, in_soft;
  logic                     hard_q, hard_d, soft_q, soft_d;
  logic                     retire, res_wr, res_rd, out_full;
  logic                     positive;
  res_t                     res_new;
  res_t                     oq_q [OUT_DEPTH];
  logic [OPTR_W-1:0]        owr_q, ord_q;
  logic [OCNT_W-1:0]        ocnt_q;

  // whole pipeline holds while a command waits for room in the result queue
  assign out_full = (ocnt_q == OCNT_W'(OUT_DEPTH));
  assign adv      = !(p_vld_q && (p_itm_q.kind == REQ_CMD) && out_full);
  assign retire   = adv && p_vld_q;

  // quadrant fold after rounding
  assign c_r = to_trig(cos_i);
  assign s_r = to_trig(sin_i);

  always_comb begin
    case (item_i.angle[15:14])
      2'd0: begin
        t_cos_d = c_r;
        t_sin_d = s_r;
      end
      2'd1: begin
        t_cos_d = -s_r;
        t_sin_d = c_r;
      end
      2'd2: begin
        t_cos_d = -c_r;
        t_sin_d = -s_r;
      end
      default: begin
        t_cos_d = s_r;
        t_sin_d = -c_r;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else if (adv) begin
      t_vld_q <= valid_i;
      p_vld_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_itm_q <= item_i;
      t_cos_q <= t_cos_d;
      t_sin_q <= t_sin_d;
      p_itm_q <= t_itm_q;
      px_q    <= $signed({1'b0, t_itm_q.range}) * t_cos_q;
      py_q    <= $signed({1'b0, t_itm_q.range}) * t_sin_q;
    end
  end

  // zone bounds, scaled like the products
  assign hb   = $signed(PROD_W'({1'b0, cfg_i.half_width} + {1'b0, cfg_i.hard_margin}))
                <<< TRIG_FRAC_BITS;
  assign sb   = $signed(PROD_W'({1'b0, cfg_i.half_width} + {1'b0, cfg_i.soft_margin}))
                <<< TRIG_FRAC_BITS;
  assign hlim = $signed(PROD_W'(cfg_i.hard_margin)) <<< TRIG_FRAC_BITS;
  assign slim = $signed(PROD_W'(cfg_i.soft_margin)) <<< TRIG_FRAC_BITS;

  assign in_hard = (py_q >= -hb) && (py_q <= hb);
  assign in_soft = (py_q >= -sb) && (py_q <= sb);

  // hard flag doubles as the scan halt: both are set and cleared together
  always_comb begin
    hard_d = hard_q;
    soft_d = soft_q;
    if (retire) begin
      case (p_itm_q.kind)
        REQ_SCAN: begin
          hard_d = 1'b0;
          soft_d = 1'b0;
        end
        REQ_POINT: begin
          if (!hard_q) begin
            if (in_hard) begin
              if (px_q <= hlim) begin
                hard_d = 1'b1;
              end
            end else if (in_soft && (px_q <= slim)) begin
              soft_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_q <= 1'b0;
      soft_q <= 1'b0;
    end else begin
      hard_q <= hard_d;
      soft_q <= soft_d;
    end
  end

  // speed limit on forward motion only
  assign positive = !p_itm_q.lin_x[15] && (p_itm_q.lin_x != '0);

  always_comb begin
    res_new.lin_x = p_itm_q.lin_x;
    if (positive) begin
      if (hard_q) begin
        res_new.lin_x = '0;
      end else if (soft_q) begin
        res_new.lin_x = $signed({1'b0, cfg_i.soft_speed});
      end
    end
    res_new.lin_y     = p_itm_q.lin_y;
    res_new.ang_z     = p_itm_q.ang_z;
    res_new.hard_zone = hard_q;
    res_new.soft_zone = soft_q;
  end

  // result queue
  assign res_wr  = retire && (p_itm_q.kind == REQ_CMD);
  assign empty_o = (ocnt_q == '0);
  assign res_rd  = pop_i && !empty_o;
  assign res_o   = oq_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (res_wr) begin
        owr_q <= owr_q + OPTR_W'(1);
      end
      if (res_rd) begin
        ord_q <= ord_q + OPTR_W'(1);
      end
      if (res_wr && !res_rd) begin
        ocnt_q <= ocnt_q + OCNT_W'(1);
      end else if (res_rd && !res_wr) begin
        ocnt_q <= ocnt_q - OCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      oq_q[owr_q] <= res_new;
    end
  end

  assign ctl_o.adv       = adv;
  assign ctl_o.hard_zone = hard_q;
  assign ctl_o.soft_zone = soft_q;

endmodule

/* hdl/lidar_safety_zone_speed_limiter.sv */
// throughput: one request per cycle while no command waits for room in the result
//   queue, set by the 30-stage cordic pipeline and the two stages of rounding and
//   projection behind it, all advancing together
// reset: zone flags and point angle cleared, registers back to their defaults,
//   both queues empty; the block takes requests from the first cycle after reset
module lidar_safety_zone_speed_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request side
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         req_type_i,
  input  logic [15:0]                        range_mm_i,
  input  logic signed [15:0]                 cmd_linear_x_i,
  input  logic signed [15:0]                 cmd_linear_y_i,
  input  logic signed [15:0]                 cmd_angular_z_i,
  // result side
  output logic                               empty,
  input  logic                               pop,
  output logic signed [15:0]                 out_linear_x_o,
  output logic signed [15:0]                 out_linear_y_o,
  output logic signed [15:0]                 out_angular_z_o,
  output logic                               hard_zone_o,
  output logic                               soft_zone_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [lszsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lszsl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import lszsl_pkg::*;

  cfg_t                 cfg_q;
  logic                 fe_wr;
  item_t                fe_item;
  logic                 q_empty;
  item_t                q_item;
  logic                 cd_vld;
  item_t                cd_item;
  logic signed [CW-1:0] cd_cos, cd_sin;
  res_t                 res;
  ctl_t                 ctl;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_width  <= 12'd200;
      cfg_q.hard_margin <= 12'd10;
      cfg_q.soft_margin <= 12'd50;
      cfg_q.soft_speed  <= 15'd10;
      cfg_q.min_range   <= 12'd10;
      cfg_q.angle_start <= 16'd0;
      cfg_q.angle_step  <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_WIDTH:  cfg_q.half_width  <= cfg_wdata_i[11:0];
        CFG_HARD_MARGIN: cfg_q.hard_margin <= cfg_wdata_i[11:0];
        CFG_SOFT_MARGIN: cfg_q.soft_margin <= cfg_wdata_i[11:0];
        CFG_SOFT_SPEED:  cfg_q.soft_speed  <= cfg_wdata_i[14:0];
        CFG_MIN_RANGE:   cfg_q.min_range   <= cfg_wdata_i[11:0];
        CFG_ANGLE_START: cfg_q.angle_start <= cfg_wdata_i;
        CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // front: classify, number the scan points, drop short ranges and unused codes
  lszsl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .req_type_i      (req_type_i),
    .range_mm_i      (range_mm_i),
    .cmd_linear_x_i  (cmd_linear_x_i),
    .cmd_linear_y_i  (cmd_linear_y_i),
    .cmd_angular_z_i (cmd_angular_z_i),
    .cfg_i           (cfg_q),
    .wr_o            (fe_wr),
    .item_o          (fe_item)
  );

  // decoupling queue; full here is full on the request side
  lszsl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fe_wr),
    .item_i  (fe_item),
    .full_o  (full),
    .rd_i    (ctl.adv),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  // sine and cosine of every item angle; scan starts and commands ride along
  lszsl_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ctl.adv),
    .valid_i (!q_empty),
    .item_i  (q_item),
    .valid_o (cd_vld),
    .item_o  (cd_item),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin)
  );

  // back: zone tests and flags in request order, speed limit, result queue
  lszsl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cd_vld),
    .item_i  (cd_item),
    .cos_i   (cd_cos),
    .sin_i   (cd_sin),
    .cfg_i   (cfg_q),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res),
    .ctl_o   (ctl)
  );

  assign out_linear_x_o  = res.lin_x;
  assign out_linear_y_o  = res.lin_y;
  assign out_angular_z_o = res.ang_z;
  assign hard_zone_o     = res.hard_zone;
  assign soft_zone_o     = res.soft_zone;

`ifndef SYNTHESIS
  // the pipeline only stalls behind waiting results
  a_stall_has_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !ctl.adv |-> !empty
  ) else $error("pipeline stalled with no result waiting");

  // a stall is released only by a result transfer
  a_stall_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (!ctl.adv && !pop) |=> !ctl.adv
  ) else $error("stall released without a result transfer");

  // zone flags never move while the pipeline is held
  a_flags_frozen : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !ctl.adv |=> ($stable(ctl.hard_zone) && $stable(ctl.soft_zone))
  ) else $error("zone flag changed during a stall");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the lidar safety zone speed limiter
// depends on lszsl_pkg and lidar_safety_zone_speed_limiter; predicts every command result itself
module testbench;
  import lszsl_pkg::*;

  // unused codes that the block must ignore
  localparam logic [1:0]           REQ_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // commands pass the queue, cordic and back end; points give no result, so allow a margin
  localparam int DRAIN_CYCLES = 40;

  // sine and cosine working values, all in q30 and turn units of 2pi/2^32
  localparam int      FRAC       = TRIG_FRAC_BITS;
  localparam int      ROUND_SH   = 30 - FRAC;
  localparam longint  TRIG_GAIN  = 64'd652032874;
  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  // arctangent of 2^-i, entry 0 at the right-hand end
  localparam logic [29:0][31:0] ATAN_TURN = {
    32'h00000001, 32'h00000002, 32'h00000005, 32'h0000000A, 32'h00000014, 32'h00000028,
    32'h00000051, 32'h000000A2, 32'h00000145, 32'h0000028B, 32'h00000517, 32'h00000A2F,
    32'h0000145F, 32'h000028BE, 32'h0000517C, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2E, 32'h0028BE53, 32'h00517C55, 32'h00A2F61E,
    32'h0145D7E1, 32'h028B0D43, 32'h051111D4, 32'h09FB385B, 32'h12E4051D, 32'h20000000
  };

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [1:0]         req_type_i;
  logic [15:0]        range_mm_i;
  logic signed [15:0] cmd_linear_x_i;
  logic signed [15:0] cmd_linear_y_i;
  logic signed [15:0] cmd_angular_z_i;
  logic               empty;
  logic               pop;
  logic signed [15:0] out_linear_x_o;
  logic signed [15:0] out_linear_y_o;
  logic signed [15:0] out_angular_z_o;
  logic               hard_zone_o;
  logic               soft_zone_o;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // shadow of the block: registers, zone flags and the running point angle
  cfg_t        zone_cfg;
  logic [15:0] angle_q;
  logic        hard_q;
  logic        soft_q;
  logic        halted_q;

  res_t due_cmds[$];       // limited commands still to come out, oldest first
  int   mismatch_count;
  int   items_sent;        // requests that the block acts on (unused codes not counted)
  logic steady;            // when set neither side idles

  lidar_safety_zone_speed_limiter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .req_type_i      (req_type_i),
    .range_mm_i      (range_mm_i),
    .cmd_linear_x_i  (cmd_linear_x_i),
    .cmd_linear_y_i  (cmd_linear_y_i),
    .cmd_angular_z_i (cmd_angular_z_i),
    .empty           (empty),
    .pop             (pop),
    .out_linear_x_o  (out_linear_x_o),
    .out_linear_y_o  (out_linear_y_o),
    .out_angular_z_o (out_angular_z_o),
    .hard_zone_o     (hard_zone_o),
    .soft_zone_o     (soft_zone_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  // q30 to trig fraction, half up, clamped to plus or minus one
  function automatic longint to_trig_frac(input longint v);
    longint r;
    r = (v + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    if (r > (longint'(1) <<< FRAC)) r = longint'(1) <<< FRAC;
    if (r < -(longint'(1) <<< FRAC)) r = -(longint'(1) <<< FRAC);
    return r;
  endfunction

  // advance the shadow by one accepted request and queue the result it causes
  task automatic track_request(input logic [1:0] req, input logic [15:0] rng_mm,
                               input logic signed [15:0] lx, input logic signed [15:0] ly,
                               input logic signed [15:0] az);
    res_t        due;
    logic [31:0] phase;
    longint      x, y, z, dx, dy, c, s, cos_v, sin_v, px, py, hb, sb;
    case (req)
      REQ_SCAN: begin
        hard_q   = 1'b0;
        soft_q   = 1'b0;
        halted_q = 1'b0;
        angle_q  = zone_cfg.angle_start;
      end
      REQ_POINT: begin
        if (!halted_q && rng_mm > {4'd0, zone_cfg.min_range}) begin
          // rotate the gain vector through the angle within its quadrant
          phase = {angle_q, 16'h0000} & PHASE_MASK;
          x = TRIG_GAIN;
          y = 0;
          z = longint'(phase[29:0]);
          for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
              x = x - dx;
              y = y + dy;
              z = z - longint'(ATAN_TURN[i]);
            end else begin
              x = x + dx;
              y = y - dy;
              z = z + longint'(ATAN_TURN[i]);
            end
          end
          c = to_trig_frac(x);
          s = to_trig_frac(y);
          case (phase[31:30])
            2'd0: begin cos_v = c;  sin_v = s;  end
            2'd1: begin cos_v = -s; sin_v = c;  end
            2'd2: begin cos_v = -c; sin_v = -s; end
            default: begin cos_v = s; sin_v = -c; end
          endcase
          px = longint'(rng_mm) * cos_v;
          py = longint'(rng_mm) * sin_v;
          hb = (longint'(zone_cfg.half_width) + longint'(zone_cfg.hard_margin)) <<< FRAC;
          sb = (longint'(zone_cfg.half_width) + longint'(zone_cfg.soft_margin)) <<< FRAC;
          // the soft band is only looked at outside the hard band
          if (py >= -hb && py <= hb) begin
            if (px <= (longint'(zone_cfg.hard_margin) <<< FRAC)) begin
              hard_q   = 1'b1;
              halted_q = 1'b1;
            end
          end else if (py >= -sb && py <= sb) begin
            if (px <= (longint'(zone_cfg.soft_margin) <<< FRAC)) soft_q = 1'b1;
          end
        end
        // the angle moves on for skipped and halted points as well
        angle_q = angle_q + zone_cfg.angle_step;
      end
      REQ_CMD: begin
        due.lin_x = lx;
        if (lx > 0) begin
          if (hard_q) due.lin_x = '0;
          else if (soft_q) due.lin_x = {1'b0, zone_cfg.soft_speed};
        end
        due.lin_y     = ly;
        due.ang_z     = az;
        due.hard_zone = hard_q;
        due.soft_zone = soft_q;
        due_cmds.push_back(due);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // every result transfer is held against the oldest queued command
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (due_cmds.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual linear x %0d",
                 $time, out_linear_x_o);
      end else begin
        want = due_cmds.pop_front();
        compare_field("linear x", want.lin_x, out_linear_x_o);
        compare_field("linear y", want.lin_y, out_linear_y_o);
        compare_field("angular z", want.ang_z, out_angular_z_o);
        compare_field("hard zone", want.hard_zone, hard_zone_o);
        compare_field("soft zone", want.soft_zone, soft_zone_o);
      end
    end
  end

  // ---------------------------------------------------------------- idling

  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: pop high except during random stalls
  initial begin
    int stall;
    pop   = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (steady) begin
        pop = 1'b1;
      end else if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one request transfer; push stays high afterwards until the next call or settle
  task automatic send_request(input logic [1:0] req, input logic [15:0] rng_mm,
                              input logic signed [15:0] lx, input logic signed [15:0] ly,
                              input logic signed [15:0] az);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push            = 1'b1;
    req_type_i      = req;
    range_mm_i      = rng_mm;
    cmd_linear_x_i  = lx;
    cmd_linear_y_i  = ly;
    cmd_angular_z_i = az;
    do @(posedge clk_i); while (full);
    track_request(req, rng_mm, lx, ly, az);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  // let the block run dry: no request, every command out, pipeline flushed
  task automatic settle();
    @(negedge clk_i);
    push = 1'b0;
    while (due_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_HALF_WIDTH:  zone_cfg.half_width  = data[11:0];
      CFG_HARD_MARGIN: zone_cfg.hard_margin = data[11:0];
      CFG_SOFT_MARGIN: zone_cfg.soft_margin = data[11:0];
      CFG_SOFT_SPEED:  zone_cfg.soft_speed  = data[14:0];
      CFG_MIN_RANGE:   zone_cfg.min_range   = data[11:0];
      CFG_ANGLE_START: zone_cfg.angle_start = data;
      CFG_ANGLE_STEP:  zone_cfg.angle_step  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_zone(input logic [15:0] half, input logic [15:0] hard_pad,
                           input logic [15:0] soft_pad, input logic [15:0] speed,
                           input logic [15:0] min_rng, input logic [15:0] start,
                           input logic [15:0] ang_step);
    write_reg(CFG_HALF_WIDTH, half);
    write_reg(CFG_HARD_MARGIN, hard_pad);
    write_reg(CFG_SOFT_MARGIN, soft_pad);
    write_reg(CFG_SOFT_SPEED, speed);
    write_reg(CFG_MIN_RANGE, min_rng);
    write_reg(CFG_ANGLE_START, start);
    write_reg(CFG_ANGLE_STEP, ang_step);
  endtask

  // a robot-sized footprint with a sweep across the front, now and then anything at all
  task automatic load_random_zone();
    if ($urandom_range(0, 4) == 0)
      load_zone(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
    else
      load_zone(16'($urandom_range(0, 400)), 16'($urandom_range(0, 100)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 32767)),
                16'($urandom_range(0, 60)),
                16'hC000 + 16'($urandom_range(0, 16'h1000)),
                16'($urandom_range(0, 16'h0400)));
  endtask

  // forward speeds with the interesting edges well represented
  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(0, 9))
      0: return 16'sh0000;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return 16'sh0001;
      4: return 16'shFFFF;
      5, 6: return 16'($urandom_range(1, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  // ranges mostly around the zones so that flags get set
  function automatic logic [15:0] rand_point_range();
    int roll;
    int bound;
    int near;
    roll  = $urandom_range(0, 99);
    bound = 2 * (zone_cfg.half_width + zone_cfg.soft_margin) + 64;
    near  = zone_cfg.min_range + $urandom_range(0, 2) - 1;
    if (roll < 50) return 16'($urandom_range(0, bound));
    if (roll < 65) return (near < 0) ? 16'd0 : 16'(near);
    if (roll < 75) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_cmd(input logic signed [15:0] lx);
    send_request(REQ_CMD, 16'($urandom), lx, 16'($urandom), 16'($urandom));
  endtask

  // scan start, a run of points with commands mixed in, and a closing command
  task automatic send_scan(input int n_points);
    send_request(REQ_SCAN, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    repeat (n_points) begin
      send_request(REQ_POINT, rand_point_range(), 16'($urandom), 16'($urandom),
                   16'($urandom));
      if ($urandom_range(0, 3) == 0) send_cmd(rand_speed());
    end
    send_cmd(rand_speed());
  endtask

  // mostly proper scans, the rest loose requests of any code
  task automatic run_traffic(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 85)
        send_scan($urandom_range(1, 24));
      else
        send_request(2'($urandom_range(0, 3)), 16'($urandom), rand_speed(),
                     16'($urandom), 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // hand-picked requests: defaults, both zones, halted scan, ignored code
  task automatic test_directed();
    // reset values, no scan start yet
    send_cmd(16'sd100);
    send_request(REQ_POINT, 16'd0, '0, '0, '0);
    send_request(REQ_POINT, 16'hFFFF, '0, '0, '0);
    send_request(REQ_CMD, 16'hFFFF, 16'shFFFF, 16'sh8000, 16'sh7FFF);
    send_request(REQ_CMD, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    settle();
    // points straight to the left
    write_reg(CFG_ANGLE_START, 16'h4000);
    write_reg(CFG_ANGLE_STEP, 16'h0000);
    send_request(REQ_SCAN, '0, '0, '0, '0);
    send_request(REQ_POINT, 16'd10, '0, '0, '0);        // at the minimum, skipped
    send_request(REQ_POINT, 16'd230, '0, '0, '0);       // soft band
    send_cmd(16'sh7FFF);
    send_cmd(16'sd3);                                   // soft speed above the command
    send_cmd(16'sd0);
    send_cmd(16'sh8000);
    send_request(REQ_POINT, 16'd150, '0, '0, '0);       // hard band, halts the scan
    send_cmd(16'sd500);
    send_request(REQ_POINT, 16'd11, '0, '0, '0);        // ignored while halted
    send_request(REQ_UNUSED, 16'hFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_cmd(16'sd1);
    send_request(REQ_SCAN, '0, '0, '0, '0);             // clears both flags
    send_cmd(16'sd200);
    send_request(REQ_POINT, 16'hFFFF, '0, '0, '0);
    send_cmd(16'sd1);
    settle();
    // unknown index leaves every register alone
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_request(REQ_SCAN, '0, '0, '0, '0);
    send_request(REQ_POINT, 16'd230, '0, '0, '0);
    send_cmd(16'sd77);
    settle();
  endtask

  // corner settings of the registers, all ones and all zero but the angle step among them
  task automatic test_extreme_settings();
    load_zone(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h4000);
    run_traffic(100);
    settle();
    load_zone(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(100);
    settle();
    load_zone(16'd4095, 16'd0, 16'd0, 16'd32767, 16'd0, 16'h8000, 16'h0001);
    run_traffic(100);
    settle();
    load_zone(16'd0, 16'd0, 16'd4095, 16'd1, 16'd4095, 16'hC000, 16'h0100);
    run_traffic(100);
    settle();
  endtask

  // the bulk: random footprints and sweeps with random traffic
  task automatic test_random_settings();
    repeat (6) begin
      load_random_zone();
      run_traffic(100);
      // hold the sender off until every command has come back
      settle();
      run_traffic(100);
      settle();
    end
  endtask

  // back-to-back transfers on both sides
  task automatic test_steady_flow();
    load_random_zone();
    steady = 1'b1;
    run_traffic(150);
    settle();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    push            = 1'b0;
    req_type_i      = REQ_SCAN;
    range_mm_i      = '0;
    cmd_linear_x_i  = '0;
    cmd_linear_y_i  = '0;
    cmd_angular_z_i = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_HALF_WIDTH;
    cfg_wdata_i     = '0;
    steady          = 1'b0;
    mismatch_count  = 0;
    items_sent      = 0;
    // register defaults and cleared state after reset
    zone_cfg.half_width  = 12'd200;
    zone_cfg.hard_margin = 12'd10;
    zone_cfg.soft_margin = 12'd50;
    zone_cfg.soft_speed  = 15'd10;
    zone_cfg.min_range   = 12'd10;
    zone_cfg.angle_start = 16'd0;
    zone_cfg.angle_step  = 16'd0;
    angle_q  = '0;
    hard_q   = 1'b0;
    soft_q   = 1'b0;
    halted_q = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_extreme_settings();
    test_random_settings();
    test_steady_flow();

    settle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* lidar_safety_zone_speed_limiter.f */
hdl/lszsl_pkg.sv
hdl/lszsl_front.sv
hdl/lszsl_fifo.sv
hdl/lszsl_cordic.sv
hdl/lszsl_back.sv
hdl/lidar_safety_zone_speed_limiter.sv
test/testbench.sv
